### rtl/hashed_name_command_parser_unit_defines.svh
// Assertion macros for the command parser checker.
`ifndef HASHED_NAME_COMMAND_PARSER_UNIT_DEFINES_SVH
`define HASHED_NAME_COMMAND_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HNCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hncp same-cycle check failed");

// Next-cycle implication.
`define HNCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hncp next-cycle check failed");

`endif

### rtl/hncp_pkg.sv
`default_nettype none
package hncp_pkg;

  typedef enum logic [2:0] {
    LS_IDLE, LS_ABORT, LS_COMMAND, LS_NAME, LS_VALUE, LS_EXECUTE
  } line_state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_R, CMD_W, CMD_X, CMD_I, CMD_D
  } cmd_letter_t;

  typedef enum logic [1:0] {
    KIND_CHAR, KIND_REG, KIND_UPDATE, KIND_UNUSED
  } item_kind_t;

  typedef enum logic [2:0] {
    RES_READ, RES_WRITE, RES_CALL, RES_REGISTERED, RES_DUPLICATE, RES_FULL
  } result_kind_t;

  typedef enum logic [1:0] {
    RT_DONE, RT_SEARCH, RT_FETCH
  } route_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DECODE, CS_SEARCH, CS_FETCH, CS_EXEC, CS_POST
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic search;
    logic exec;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    route_t route;
    logic   hit;
    logic   miss;
    logic   hold_has;
    logic   out_free;
  } dp_stat_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam logic [31:0] HASH_OFFSET = 32'h811C9DC5;
  localparam logic [31:0] HASH_PRIME  = 32'h01000193;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [2:0] NEED_READ  = 3'b001;
  localparam logic [2:0] NEED_WRITE = 3'b010;
  localparam logic [2:0] NEED_RW    = 3'b011;
  localparam logic [2:0] NEED_CALL  = 3'b100;

  function automatic logic [31:0] size_mask(input logic [1:0] code);
    logic [31:0] m;
    case (code)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_HALF: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/hashed_name_command_parser_unit.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid/in_stall   | kind, char, hash, attrs, index, value
// out_    | output    | out_valid/out_stall | result kind, slot, value, size
//
// A character that needs no table access passes through capture and decode only.
// Name end and registration add a linear search over the table entries,
// then pass through the fetch, execute and output hand-off states.
// Line execution and in-range updates skip the search (one table read port).
// Reset clears the parser and empties the table; no clearing pass.
// A result waits in the output register while the next word is taken; a second
// result holds the input stalled until the output register frees up.
`default_nettype none
module hashed_name_command_parser_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic [31:0] in_name_hash,
  input  wire logic [1:0]  in_access_mode,
  input  wire logic        in_value_type,
  input  wire logic [1:0]  in_size_code,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic [31:0] in_new_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_kind,
  output logic [4:0]       out_entry_slot,
  output logic [31:0]      out_result_value,
  output logic [1:0]       out_result_size
);

  hncp_pkg::dp_cmd_t  cmd;
  hncp_pkg::dp_stat_t st;

  hncp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  hncp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_kind          (in_kind),
    .in_char_byte     (in_char_byte),
    .in_name_hash     (in_name_hash),
    .in_access_mode   (in_access_mode),
    .in_value_type    (in_value_type),
    .in_size_code     (in_size_code),
    .in_entry_index   (in_entry_index),
    .in_new_value     (in_new_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_entry_slot   (out_entry_slot),
    .out_result_value (out_result_value),
    .out_result_size  (out_result_size)
  );

endmodule
`default_nettype wire

### rtl/hncp_ctrl.sv
`default_nettype none
module hncp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire hncp_pkg::dp_stat_t st,
  output hncp_pkg::dp_cmd_t       cmd,
  output logic                    in_stall
);

  hncp_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hncp_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      hncp_pkg::CS_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = hncp_pkg::CS_DECODE;
      end
      hncp_pkg::CS_DECODE: begin
        cmd.decode = 1'b1;
        case (st.route)
          hncp_pkg::RT_SEARCH: state_nxt = hncp_pkg::CS_SEARCH;
          hncp_pkg::RT_FETCH:  state_nxt = hncp_pkg::CS_FETCH;
          default:             state_nxt = hncp_pkg::CS_IDLE;
        endcase
      end
      hncp_pkg::CS_SEARCH: begin
        cmd.search = 1'b1;
        if (st.hit || st.miss) state_nxt = hncp_pkg::CS_FETCH;
      end
      // wait state for the registered table read
      hncp_pkg::CS_FETCH: state_nxt = hncp_pkg::CS_EXEC;
      hncp_pkg::CS_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = hncp_pkg::CS_POST;
      end
      hncp_pkg::CS_POST: begin
        if (!st.hold_has) begin
          state_nxt = hncp_pkg::CS_IDLE;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = hncp_pkg::CS_IDLE;
        end
      end
      default: state_nxt = hncp_pkg::CS_IDLE;
    endcase
  end

  assign in_stall = (state_r != hncp_pkg::CS_IDLE);

endmodule
`default_nettype wire

### rtl/hncp_dp.sv
`default_nettype none
module hncp_dp #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hncp_pkg::dp_cmd_t cmd,
  output hncp_pkg::dp_stat_t     st,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_char_byte,
  input  wire logic [31:0]       in_name_hash,
  input  wire logic [1:0]        in_access_mode,
  input  wire logic              in_value_type,
  input  wire logic [1:0]        in_size_code,
  input  wire logic [4:0]        in_entry_index,
  input  wire logic [31:0]       in_new_value,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [2:0]             out_result_kind,
  output logic [4:0]             out_entry_slot,
  output logic [31:0]            out_result_value,
  output logic [1:0]             out_result_size
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam logic [32:0] WMASK33 = (33'd1 << VALUE_WIDTH) - 33'd1;
  localparam logic [31:0] WMASK   = WMASK33[31:0];

  // table
  logic [31:0]            hash_mem [TABLE_DEPTH];
  logic [4:0]             attr_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
  logic [31:0]            hash_q_r;
  logic [4:0]             attr_q_r;
  logic [VALUE_WIDTH-1:0] val_q_r;
  logic [IW-1:0]          rd_addr;
  logic                   we_ent, we_val;
  logic [IW-1:0]          wa;
  logic [31:0]            w_hash;
  logic [4:0]             w_attr;
  logic [VALUE_WIDTH-1:0] w_val;

  // captured word
  hncp_pkg::item_kind_t kind_r;
  logic [7:0]  chr_r;
  logic [31:0] ihash_r, nval_r;
  logic [1:0]  acc_r, sz_r;
  logic        typ_r;
  logic [4:0]  idx_r;

  // line parser
  hncp_pkg::line_state_t line_r, line_nxt, dec_line;
  hncp_pkg::cmd_letter_t cmdl_r, cmdl_nxt, dec_cmdl;
  logic [31:0] rhash_r, rhash_nxt, dec_hash;
  logic        pend_r, pend_nxt, dec_pend;
  logic [31:0] accum_r, accum_nxt, dec_accum;
  logic        started_r, started_nxt, dec_started;
  logic        neg_r, neg_nxt, dec_neg;
  logic [IW-1:0] cur_r, cur_nxt;
  logic        cur_uns_r, cur_uns_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // search
  logic [CW-1:0] s_r, s_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0] fa_r, fa_nxt, dec_fa;
  logic          found_r, found_nxt;
  logic          issue, hit, miss;
  logic [31:0]   key;

  // result hold and output
  logic        hold_has_r, hold_has_nxt;
  logic [2:0]  hold_kind_r, hold_kind_nxt;
  logic [4:0]  hold_slot_r, hold_slot_nxt;
  logic [31:0] hold_val_r, hold_val_nxt;
  logic [1:0]  hold_size_r, hold_size_nxt;
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [4:0]  out_slot_r;
  logic [31:0] out_val_r;
  logic [1:0]  out_size_r;

  hncp_pkg::route_t route;
  logic is_nl, is_sp, is_dig, is_alpha, name_ch;
  logic [31:0] prod, hash_in, accum10;
  logic dclr, dabt;

  function automatic logic [31:0] in_mask(input logic [31:0] x, input logic [1:0] code);
    return x & hncp_pkg::size_mask(code) & WMASK;
  endfunction

  assign is_nl    = (chr_r == hncp_pkg::CH_NL);
  assign is_sp    = (chr_r == hncp_pkg::CH_SP);
  assign is_dig   = (chr_r >= hncp_pkg::CH_0) && (chr_r <= hncp_pkg::CH_9);
  assign is_alpha = ((chr_r >= hncp_pkg::CH_UA) && (chr_r <= hncp_pkg::CH_UZ)) ||
                    ((chr_r >= hncp_pkg::CH_LA) && (chr_r <= hncp_pkg::CH_LZ));
  assign name_ch  = is_alpha || is_dig || (chr_r == hncp_pkg::CH_US);

  assign hash_in = pend_r ? rhash_r : hncp_pkg::HASH_OFFSET;
  assign prod    = (hash_in ^ {24'd0, chr_r}) * hncp_pkg::HASH_PRIME;
  assign accum10 = (accum_r << 3) + (accum_r << 1) + {24'd0, chr_r - hncp_pkg::CH_0};

  // decode of the captured word: simple character steps, or a route to a table access
  always_comb begin
    route       = hncp_pkg::RT_DONE;
    dec_line    = line_r;
    dec_cmdl    = cmdl_r;
    dec_hash    = rhash_r;
    dec_pend    = pend_r;
    dec_accum   = accum_r;
    dec_started = started_r;
    dec_neg     = neg_r;
    dec_fa      = fa_r;
    dclr        = 1'b0;
    dabt        = 1'b0;
    case (kind_r)
      hncp_pkg::KIND_CHAR: begin
        case (line_r)
          hncp_pkg::LS_ABORT: dclr = is_nl;
          hncp_pkg::LS_COMMAND: begin
            if (is_nl) dclr = 1'b1;
            else if (is_sp) begin
              dec_line = hncp_pkg::LS_NAME;
              dec_pend = 1'b0;
            end else dabt = 1'b1;
          end
          hncp_pkg::LS_NAME: begin
            if (is_nl || is_sp) begin
              if (pend_r) route = hncp_pkg::RT_SEARCH;
              else if (is_nl) dclr = 1'b1;
              else dabt = 1'b1;
            end else if (pend_r ? name_ch : is_alpha) begin
              dec_hash = prod;
              dec_pend = 1'b1;
            end else dabt = 1'b1;
          end
          hncp_pkg::LS_VALUE: begin
            if (is_sp) dec_line = hncp_pkg::LS_EXECUTE;
            else if (is_nl) begin
              route  = hncp_pkg::RT_FETCH;
              dec_fa = cur_r;
            end else if (is_dig) begin
              dec_accum   = accum10;
              dec_started = 1'b1;
            end else if (!cur_uns_r && (chr_r == hncp_pkg::CH_MINUS) && !started_r && !neg_r) begin
              dec_neg = 1'b1;
            end else dabt = 1'b1;
          end
          hncp_pkg::LS_EXECUTE: begin
            if (is_nl) begin
              route  = hncp_pkg::RT_FETCH;
              dec_fa = cur_r;
            end else if (!is_sp) dabt = 1'b1;
          end
          default: begin
            dec_line = hncp_pkg::LS_COMMAND;
            case (chr_r)
              hncp_pkg::CH_R: dec_cmdl = hncp_pkg::CMD_R;
              hncp_pkg::CH_W: dec_cmdl = hncp_pkg::CMD_W;
              hncp_pkg::CH_X: dec_cmdl = hncp_pkg::CMD_X;
              hncp_pkg::CH_I: dec_cmdl = hncp_pkg::CMD_I;
              hncp_pkg::CH_D: dec_cmdl = hncp_pkg::CMD_D;
              hncp_pkg::CH_NL: dclr = 1'b1;
              default: dabt = 1'b1;
            endcase
          end
        endcase
      end
      hncp_pkg::KIND_REG: route = hncp_pkg::RT_SEARCH;
      hncp_pkg::KIND_UPDATE: begin
        if (CMPW'(idx_r) < CMPW'(count_r)) begin
          route  = hncp_pkg::RT_FETCH;
          dec_fa = IW'(idx_r);
        end
      end
      default: route = hncp_pkg::RT_DONE;
    endcase
    if (dclr) begin
      dec_line    = hncp_pkg::LS_IDLE;
      dec_pend    = 1'b0;
      dec_started = 1'b0;
      dec_neg     = 1'b0;
      dec_accum   = 32'd0;
    end
    if (dabt) begin
      dec_line = hncp_pkg::LS_ABORT;
      dec_pend = 1'b0;
    end
  end

  // linear search, one entry per cycle behind the registered read
  assign key   = (kind_r == hncp_pkg::KIND_REG) ? ihash_r : rhash_r;
  assign issue = (s_r < count_r);
  assign hit   = cmp_v_r && (hash_q_r == key);
  assign miss  = !cmp_v_r && !issue;
  assign rd_addr = cmd.search ? s_r[IW-1:0] : fa_r;

  always_comb begin
    logic [31:0] m, stored, opnd, v, newv;
    logic [2:0]  need, have;
    logic [1:0]  sz_eff;
    logic        ok, run, eclr, eabt;
    m      = hncp_pkg::size_mask(attr_q_r[4:3]) & WMASK;
    stored = 32'(val_q_r);
    opnd   = neg_r ? (32'd0 - accum_r) : accum_r;
    v      = 32'd0;
    newv   = 32'd0;
    need   = hncp_pkg::NEED_RW;
    have   = 3'({1'b0, attr_q_r[1:0]}) + 3'd1;
    sz_eff = (sz_r == 2'd3) ? hncp_pkg::SZ_WORD : sz_r;
    ok     = 1'b0;
    run    = 1'b0;
    eclr   = 1'b0;
    eabt   = 1'b0;

    line_nxt    = line_r;
    cmdl_nxt    = cmdl_r;
    rhash_nxt   = rhash_r;
    pend_nxt    = pend_r;
    accum_nxt   = accum_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    cur_nxt     = cur_r;
    cur_uns_nxt = cur_uns_r;
    count_nxt   = count_r;
    s_nxt       = s_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    fa_nxt      = fa_r;
    found_nxt   = found_r;
    hold_has_nxt  = hold_has_r;
    hold_kind_nxt = hold_kind_r;
    hold_slot_nxt = hold_slot_r;
    hold_val_nxt  = hold_val_r;
    hold_size_nxt = hold_size_r;
    we_ent = 1'b0;
    we_val = 1'b0;
    wa     = fa_r;
    w_hash = ihash_r;
    w_attr = {sz_eff, typ_r, acc_r};
    w_val  = '0;

    if (cmd.decode) begin
      line_nxt    = dec_line;
      cmdl_nxt    = dec_cmdl;
      rhash_nxt   = dec_hash;
      pend_nxt    = dec_pend;
      accum_nxt   = dec_accum;
      started_nxt = dec_started;
      neg_nxt     = dec_neg;
      fa_nxt      = dec_fa;
      s_nxt       = '0;
      cmp_v_nxt   = 1'b0;
    end

    if (cmd.search) begin
      s_nxt       = s_r + CW'(issue);
      cmp_v_nxt   = issue;
      cmp_idx_nxt = s_r[IW-1:0];
      if (hit) begin
        found_nxt = 1'b1;
        fa_nxt    = cmp_idx_r;
      end else if (miss) begin
        found_nxt = 1'b0;
      end
    end

    if (cmd.exec) begin
      case (kind_r)
        hncp_pkg::KIND_CHAR: begin
          if (line_r == hncp_pkg::LS_NAME) begin
            pend_nxt = 1'b0;
            case (cmdl_r)
              hncp_pkg::CMD_R: need = hncp_pkg::NEED_READ;
              hncp_pkg::CMD_W: need = hncp_pkg::NEED_WRITE;
              hncp_pkg::CMD_X: need = hncp_pkg::NEED_CALL;
              default:         need = hncp_pkg::NEED_RW;
            endcase
            ok = found_r && ((have & need) == need);
            if (!ok) begin
              if (is_nl) eclr = 1'b1;
              else eabt = 1'b1;
            end else begin
              cur_nxt     = fa_r;
              cur_uns_nxt = attr_q_r[2];
              started_nxt = 1'b0;
              neg_nxt     = 1'b0;
              accum_nxt   = 32'd0;
              if (cmdl_r == hncp_pkg::CMD_R || cmdl_r == hncp_pkg::CMD_X) begin
                line_nxt = hncp_pkg::LS_EXECUTE;
                run      = is_nl;
              end else if (is_nl) eclr = 1'b1;
              else line_nxt = hncp_pkg::LS_VALUE;
            end
          end else begin
            run = 1'b1;
          end
          if (run) begin
            eclr = 1'b1;
            case (cmdl_r)
              hncp_pkg::CMD_R: begin
                hold_has_nxt  = 1'b1;
                hold_kind_nxt = hncp_pkg::RES_READ;
                hold_val_nxt  = stored & m;
              end
              hncp_pkg::CMD_X: begin
                hold_has_nxt  = 1'b1;
                hold_kind_nxt = hncp_pkg::RES_CALL;
                hold_val_nxt  = 32'd0;
              end
              hncp_pkg::CMD_W, hncp_pkg::CMD_I, hncp_pkg::CMD_D: begin
                if (started_r) begin
                  if (cmdl_r == hncp_pkg::CMD_W) v = opnd;
                  else if (cmdl_r == hncp_pkg::CMD_I) v = stored + opnd;
                  else v = stored - opnd;
                  v = v & m;
                  we_val        = 1'b1;
                  w_val         = VALUE_WIDTH'(v);
                  hold_has_nxt  = 1'b1;
                  hold_kind_nxt = hncp_pkg::RES_WRITE;
                  hold_val_nxt  = v;
                end
              end
              default: hold_has_nxt = hold_has_r;
            endcase
            hold_slot_nxt = 5'(fa_r);
            hold_size_nxt = attr_q_r[4:3];
          end
        end
        hncp_pkg::KIND_REG: begin
          hold_has_nxt = 1'b1;
          if (found_r) begin
            hold_kind_nxt = hncp_pkg::RES_DUPLICATE;
            hold_slot_nxt = 5'(fa_r);
            hold_val_nxt  = stored & m;
            hold_size_nxt = attr_q_r[4:3];
          end else if (count_r >= CW'(TABLE_DEPTH)) begin
            hold_kind_nxt = hncp_pkg::RES_FULL;
            hold_slot_nxt = 5'd0;
            hold_val_nxt  = 32'd0;
            hold_size_nxt = 2'd0;
          end else begin
            newv          = in_mask(nval_r, sz_eff);
            we_ent        = 1'b1;
            we_val        = 1'b1;
            wa            = count_r[IW-1:0];
            w_val         = VALUE_WIDTH'(newv);
            count_nxt     = count_r + CW'(1);
            hold_kind_nxt = hncp_pkg::RES_REGISTERED;
            hold_slot_nxt = 5'(count_r[IW-1:0]);
            hold_val_nxt  = newv;
            hold_size_nxt = sz_eff;
          end
        end
        hncp_pkg::KIND_UPDATE: begin
          we_val = 1'b1;
          w_val  = VALUE_WIDTH'(nval_r & m);
        end
        default: we_val = 1'b0;
      endcase
      if (eclr) begin
        line_nxt    = hncp_pkg::LS_IDLE;
        pend_nxt    = 1'b0;
        started_nxt = 1'b0;
        neg_nxt     = 1'b0;
        accum_nxt   = 32'd0;
      end
      if (eabt) begin
        line_nxt = hncp_pkg::LS_ABORT;
        pend_nxt = 1'b0;
      end
    end

    if (cmd.out_load) hold_has_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (we_ent) begin
      hash_mem[wa] <= w_hash;
      attr_mem[wa] <= w_attr;
    end
    if (we_val) val_mem[wa] <= w_val;
    hash_q_r <= hash_mem[rd_addr];
    attr_q_r <= attr_mem[rd_addr];
    val_q_r  <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= hncp_pkg::LS_IDLE;
      cmdl_r      <= hncp_pkg::CMD_NONE;
      rhash_r     <= 32'd0;
      pend_r      <= 1'b0;
      accum_r     <= 32'd0;
      started_r   <= 1'b0;
      neg_r       <= 1'b0;
      cur_r       <= '0;
      cur_uns_r   <= 1'b0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      hold_has_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      cmdl_r      <= cmdl_nxt;
      rhash_r     <= rhash_nxt;
      pend_r      <= pend_nxt;
      accum_r     <= accum_nxt;
      started_r   <= started_nxt;
      neg_r       <= neg_nxt;
      cur_r       <= cur_nxt;
      cur_uns_r   <= cur_uns_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      found_r     <= found_nxt;
      hold_has_r  <= hold_has_nxt;
      out_valid_r <= (out_valid_r && out_stall) || cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= hncp_pkg::item_kind_t'(in_kind);
      chr_r   <= in_char_byte;
      ihash_r <= in_name_hash;
      acc_r   <= in_access_mode;
      typ_r   <= in_value_type;
      sz_r    <= in_size_code;
      idx_r   <= in_entry_index;
      nval_r  <= in_new_value;
    end
    s_r         <= s_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    fa_r        <= fa_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_slot_r <= hold_slot_nxt;
    hold_val_r  <= hold_val_nxt;
    hold_size_r <= hold_size_nxt;
    if (cmd.out_load) begin
      out_kind_r <= hold_kind_r;
      out_slot_r <= hold_slot_r;
      out_val_r  <= hold_val_r;
      out_size_r <= hold_size_r;
    end
  end

  assign st.route    = route;
  assign st.hit      = hit;
  assign st.miss     = miss;
  assign st.hold_has = hold_has_r;
  assign st.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_entry_slot   = out_slot_r;
  assign out_result_value = out_val_r;
  assign out_result_size  = out_size_r;

endmodule
`default_nettype wire

### rtl/hncp_checker.sv
`default_nettype none
`include "hashed_name_command_parser_unit_defines.svh"
module hncp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_result_kind,
  input wire logic [4:0]  out_entry_slot,
  input wire logic [31:0] out_result_value,
  input wire logic [1:0]  out_result_size
);

  // a taken word always raises in_stall before the next word can be taken
  `HNCP_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `HNCP_ASSERT_NOW(a_full_zero, out_valid && (out_result_kind == hncp_pkg::RES_FULL), (out_entry_slot == 5'd0) && (out_result_value == 32'd0) && (out_result_size == 2'd0))
  `HNCP_ASSERT_NOW(a_size_code, out_valid, out_result_size != 2'd3)
  `HNCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind hashed_name_command_parser_unit hncp_checker u_hncp_checker (.*);
`default_nettype wire

### sim/tb_hashed_name_command_parser_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_hashed_name_command_parser_unit;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [31:0] hash;
    logic [1:0]  access;
    logic        vtype;
    logic [1:0]  size;
    logic [4:0]  index;
    logic [31:0] value;
  } word_t;

  typedef struct packed {
    logic [2:0]  rkind;
    logic [4:0]  slot;
    logic [31:0] value;
    logic [1:0]  size;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [7:0] in_char_byte = '0;
  logic [31:0] in_name_hash = '0;
  logic [1:0] in_access_mode = '0;
  logic in_value_type = 1'b0;
  logic [1:0] in_size_code = '0;
  logic [4:0] in_entry_index = '0;
  logic [31:0] in_new_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_result_kind;
  logic [4:0] out_entry_slot;
  logic [31:0] out_result_value;
  logic [1:0] out_result_size;

  hashed_name_command_parser_unit u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // parser shadow state
  hncp_pkg::line_state_t ls;
  hncp_pkg::cmd_letter_t letter;
  logic [31:0] run_hash, accum;
  logic pending, started, negative;
  int cur, count;
  logic [31:0] tbl_hash [DEPTH];
  logic [4:0]  tbl_attr [DEPTH];
  logic [31:0] tbl_val  [DEPTH];

  // names sent for registration so far, to build good lines
  string known_name [$];

  word_t pending_words [$];
  reply_t expected_replies [$];
  int errors = 0;
  bit stim_done = 0;
  int hold_cycles = 0;

  function automatic logic [31:0] mask_of(logic [1:0] code);
    return code == hncp_pkg::SZ_BYTE ? 32'hFF :
           code == hncp_pkg::SZ_HALF ? 32'hFFFF : 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] fnv(string s);
    logic [31:0] h;
    h = hncp_pkg::HASH_OFFSET;
    for (int i = 0; i < s.len(); i++) h = (h ^ {24'd0, s[i]}) * hncp_pkg::HASH_PRIME;
    return h;
  endfunction

  function void line_reset();
    ls = hncp_pkg::LS_IDLE; pending = 0; started = 0; negative = 0; accum = '0;
  endfunction

  function void line_bad();
    ls = hncp_pkg::LS_ABORT; pending = 0;
  endfunction

  function void push(hncp_pkg::result_kind_t k, int slot, logic [31:0] v, logic [1:0] sz);
    expected_replies.push_back('{k, slot[4:0], v, sz});
  endfunction

  function void execute_line();
    logic [1:0] sz;
    logic [31:0] m, opnd, v;
    if (cur < count) begin
      sz = tbl_attr[cur][4:3];
      m = mask_of(sz);
      opnd = negative ? -accum : accum;
      case (letter)
        hncp_pkg::CMD_R: push(hncp_pkg::RES_READ, cur, tbl_val[cur] & m, sz);
        hncp_pkg::CMD_X: push(hncp_pkg::RES_CALL, cur, '0, sz);
        hncp_pkg::CMD_W, hncp_pkg::CMD_I, hncp_pkg::CMD_D: if (started) begin
          v = letter == hncp_pkg::CMD_W ? opnd :
              letter == hncp_pkg::CMD_I ? tbl_val[cur] + opnd : tbl_val[cur] - opnd;
          v &= m;
          tbl_val[cur] = v;
          push(hncp_pkg::RES_WRITE, cur, v, sz);
        end
        default: ;
      endcase
    end
    line_reset();
  endfunction

  function void finish_name(logic [7:0] c);
    logic [2:0] need, have;
    int hit;
    if (!pending) begin
      if (c == hncp_pkg::CH_NL) line_reset(); else line_bad();
      return;
    end
    pending = 0;
    need = letter == hncp_pkg::CMD_R ? hncp_pkg::NEED_READ :
           letter == hncp_pkg::CMD_W ? hncp_pkg::NEED_WRITE :
           letter == hncp_pkg::CMD_X ? hncp_pkg::NEED_CALL : hncp_pkg::NEED_RW;
    hit = -1;
    for (int i = 0; i < count; i++)
      if (hit < 0 && tbl_hash[i] == run_hash) hit = i;
    have = hit < 0 ? 3'b000 : 3'(tbl_attr[hit][1:0]) + 3'd1;
    if (hit < 0 || (have & need) != need) begin
      if (c == hncp_pkg::CH_NL) line_reset(); else line_bad();
      return;
    end
    cur = hit; started = 0; negative = 0; accum = '0;
    if (letter == hncp_pkg::CMD_R || letter == hncp_pkg::CMD_X) begin
      ls = hncp_pkg::LS_EXECUTE;
      if (c == hncp_pkg::CH_NL) execute_line();
    end else if (c == hncp_pkg::CH_NL) line_reset();
    else ls = hncp_pkg::LS_VALUE;
  endfunction

  function bit is_alpha(logic [7:0] c);
    return (c >= hncp_pkg::CH_UA && c <= hncp_pkg::CH_UZ) ||
           (c >= hncp_pkg::CH_LA && c <= hncp_pkg::CH_LZ);
  endfunction

  function void parse_char(logic [7:0] c);
    case (ls)
      hncp_pkg::LS_ABORT: if (c == hncp_pkg::CH_NL) line_reset();
      hncp_pkg::LS_COMMAND:
        if (c == hncp_pkg::CH_NL) line_reset();
        else if (c == hncp_pkg::CH_SP) begin ls = hncp_pkg::LS_NAME; pending = 0; end
        else line_bad();
      hncp_pkg::LS_NAME:
        if (c == hncp_pkg::CH_NL || c == hncp_pkg::CH_SP) finish_name(c);
        else if (pending) begin
          if (is_alpha(c) || (c >= hncp_pkg::CH_0 && c <= hncp_pkg::CH_9) ||
              c == hncp_pkg::CH_US)
            run_hash = (run_hash ^ {24'd0, c}) * hncp_pkg::HASH_PRIME;
          else line_bad();
        end else if (is_alpha(c)) begin
          run_hash = (hncp_pkg::HASH_OFFSET ^ {24'd0, c}) * hncp_pkg::HASH_PRIME;
          pending = 1;
        end else line_bad();
      hncp_pkg::LS_VALUE:
        if (c == hncp_pkg::CH_SP) ls = hncp_pkg::LS_EXECUTE;
        else if (c == hncp_pkg::CH_NL) execute_line();
        else if (c >= hncp_pkg::CH_0 && c <= hncp_pkg::CH_9) begin
          accum = accum * 32'd10 + {24'd0, c - hncp_pkg::CH_0};
          started = 1;
        end else if (!tbl_attr[cur][2] && c == hncp_pkg::CH_MINUS && !started && !negative)
          negative = 1;
        else line_bad();
      hncp_pkg::LS_EXECUTE:
        if (c == hncp_pkg::CH_NL) execute_line();
        else if (c != hncp_pkg::CH_SP) line_bad();
      default: begin
        ls = hncp_pkg::LS_COMMAND;
        case (c)
          hncp_pkg::CH_NL: line_reset();
          hncp_pkg::CH_R: letter = hncp_pkg::CMD_R;
          hncp_pkg::CH_W: letter = hncp_pkg::CMD_W;
          hncp_pkg::CH_X: letter = hncp_pkg::CMD_X;
          hncp_pkg::CH_I: letter = hncp_pkg::CMD_I;
          hncp_pkg::CH_D: letter = hncp_pkg::CMD_D;
          default: line_bad();
        endcase
      end
    endcase
  endfunction

  function void predict_word(word_t w);
    logic [1:0] sz;
    case (w.kind)
      hncp_pkg::KIND_CHAR: parse_char(w.ch);
      hncp_pkg::KIND_REG: begin
        sz = w.size == 2'd3 ? hncp_pkg::SZ_WORD : w.size;
        for (int i = 0; i < count; i++)
          if (tbl_hash[i] == w.hash) begin
            push(hncp_pkg::RES_DUPLICATE, i, tbl_val[i] & mask_of(tbl_attr[i][4:3]),
                 tbl_attr[i][4:3]);
            return;
          end
        if (count >= DEPTH) push(hncp_pkg::RES_FULL, 0, '0, '0);
        else begin
          tbl_hash[count] = w.hash;
          tbl_attr[count] = {sz, w.vtype, w.access};
          tbl_val[count] = w.value & mask_of(sz);
          push(hncp_pkg::RES_REGISTERED, count, tbl_val[count], sz);
          count++;
        end
      end
      hncp_pkg::KIND_UPDATE:
        if (w.index < count) tbl_val[w.index] = w.value & mask_of(tbl_attr[w.index][4:3]);
      default: ;
    endcase
  endfunction

  task automatic report(string what, reply_t got, reply_t want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic word_t rand_word();
    word_t w;
    w = '{2'($urandom_range(0, 3)), 8'($urandom), $urandom, 2'($urandom), 1'($urandom),
          2'($urandom), 5'($urandom), $urandom};
    return w;
  endfunction

  task automatic send_char(logic [7:0] c);
    word_t w;
    w = rand_word();
    w.kind = hncp_pkg::KIND_CHAR;
    w.ch = c;
    pending_words.push_back(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic register(string name, logic [1:0] mode, logic t, logic [1:0] sz,
                          logic [31:0] v);
    word_t w;
    w = rand_word();
    w.kind = hncp_pkg::KIND_REG; w.hash = fnv(name); w.access = mode; w.vtype = t;
    w.size = sz; w.value = v;
    pending_words.push_back(w);
    known_name.push_back(name);
  endtask

  function automatic string rand_name();
    string s, set;
    int n, k;
    set = "abcxyzAZ019_";
    s = $urandom_range(0, 1) ? "a" : "Z";
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 11);
      s = {s, set.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string rand_line();
    string cmds, s, name;
    int k, c;
    cmds = "RWXID";
    k = known_name.size() ? $urandom_range(0, known_name.size() - 1) : 0;
    name = known_name.size() ? known_name[k] : "q";
    c = $urandom_range(0, 4);
    s = {cmds.substr(c, c), " ", name};
    case ($urandom_range(0, 5))
      0: ;
      1: s = {s, " "};
      2: s = {s, " -", $sformatf("%0d", $urandom)};
      3: s = {s, " ", $sformatf("%0d%0d", $urandom, $urandom_range(0, 99))};
      default: s = {s, " ", $sformatf("%0d", $urandom_range(0, 300)),
                    $urandom_range(0, 1) ? " " : ""};
    endcase
    if ($urandom_range(0, 9) == 0) s = {s, "!"};
    return {s, "\n"};
  endfunction

  initial begin
    word_t w;
    string line;
    line_reset();
    letter = hncp_pkg::CMD_NONE; run_hash = '0; cur = 0; count = 0;
    // directed lines and registrations
    register("a", 2'd0, 1'b0, hncp_pkg::SZ_BYTE, 32'hFFFF_FFFF);
    register("Zz_9", 2'd2, 1'b0, hncp_pkg::SZ_HALF, 32'h1234_5678);
    register("wo", 2'd1, 1'b1, 2'd3, 32'hFFFF_FFFF);
    register("fn", 2'd3, 1'b1, hncp_pkg::SZ_WORD, 32'h0);
    register("a", 2'd2, 1'b1, hncp_pkg::SZ_WORD, 32'h5);
    send_text("R a\nW Zz_9 -70000\nI Zz_9 4294967295\nD Zz_9\nX fn \n");
    send_text("W wo 99999999999 \nR wo\nR  a\nR 9a\nQ\n\nW wo -1\nD a 1\nR nope\n");
    w = rand_word(); w.kind = hncp_pkg::KIND_UPDATE; w.index = 5'd31;
    pending_words.push_back(w);
    w.index = 5'd1; w.value = 32'hFFFF_FFFF; pending_words.push_back(w);
    w.kind = hncp_pkg::KIND_UNUSED; pending_words.push_back(w);
    send_text("R Zz_9\n");
    for (int i = known_name.size(); i < DEPTH + 2; i++) begin
      line = rand_name();
      line = {line, $sformatf("n%0d", i)};
      register(line, 2'($urandom), 1'($urandom), 2'($urandom), $urandom);
    end
    while (pending_words.size() < 1150) begin
      case ($urandom_range(0, 19))
        0: pending_words.push_back(rand_word());
        1: send_char(8'($urandom));
        2: begin
          w = rand_word(); w.kind = hncp_pkg::KIND_UPDATE; pending_words.push_back(w);
        end
        3: register(known_name[$urandom_range(0, known_name.size() - 1)], 2'd0, 1'b0,
                    hncp_pkg::SZ_BYTE, 32'd0);
        default: send_text(rand_line());
      endcase
    end
    send_char(hncp_pkg::CH_NL);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic w_drive(word_t w);
    in_kind <= w.kind; in_char_byte <= w.ch; in_name_hash <= w.hash;
    in_access_mode <= w.access; in_value_type <= w.vtype; in_size_code <= w.size;
    in_entry_index <= w.index; in_new_value <= w.value;
  endtask

  // sender
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (in_valid && !in_stall) predict_word(pending_words.pop_front());
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_words.size() &&
          (cyc > 1600 && cyc < 2600 || $urandom_range(0, 99) >= 31)) begin
        w_drive(pending_words[0]);
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end
    if (rst_n && !pending_words.size() && !(in_valid && !in_stall) && !in_valid)
      stim_done <= 1'b1;
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (cyc == 1000) hold_cycles <= 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver
  always @(posedge clk) begin
    reply_t got, want;
    if (out_valid && !out_stall) begin
      got = '{out_result_kind, out_entry_slot, out_result_value, out_result_size};
      if (!expected_replies.size()) report("unexpected", got, '0);
      else begin
        want = expected_replies.pop_front();
        if (got.rkind != want.rkind) report("kind", got, want);
        if (got.slot != want.slot) report("slot", got, want);
        if (got.value != want.value) report("value", got, want);
        if (got.size != want.size) report("size", got, want);
      end
    end
    if (hold_cycles > 0) out_stall <= 1'b1;
    else if (cyc > 1600 && cyc < 2600) out_stall <= 1'b0;
    else out_stall <= $urandom_range(0, 99) < 31;
  end

  initial begin
    wait (stim_done);
    wait (expected_replies.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/hncp_pkg.sv
rtl/hncp_ctrl.sv
rtl/hncp_dp.sv
rtl/hashed_name_command_parser_unit.sv
rtl/hncp_checker.sv
sim/tb_hashed_name_command_parser_unit.sv
